### hw/rtl/mtt_pkg.sv
// ----------------------------------------------------------------------------
// mtt_pkg
// Shared types and constants of the point mover: word layouts, action and
// register codes, fixed-point widths and the sequencer states.
// ----------------------------------------------------------------------------
package mtt_pkg;

    localparam int FIELD_W = 24;
    localparam int DIR_W   = 16;
    localparam int DIR_FRAC = 15;
    localparam int DT_W    = 16;
    localparam int SPEED_W = 24;
    localparam int ACT_W   = 2;

    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int APB_IDX_LSB = 2;

    localparam logic [APB_AW-APB_IDX_LSB-1:0] REG_MOVE_SPEED = '0;
    localparam logic [SPEED_W-1:0]            SPEED_RESET    = 24'd256;

    localparam logic [ACT_W-1:0] ACT_TICK     = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SET_DEST = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PLACE    = 2'd2;

    localparam int QUOT_W       = 16;
    localparam int M_W          = SPEED_W + DT_W;
    localparam int PROD_W       = M_W + QUOT_W;
    localparam int ROUND_BIT    = 30;
    localparam int STEP_SHIFT   = 31;
    localparam int STEP_W       = PROD_W - STEP_SHIFT;
    localparam int ARRIVE_SHIFT = 16;

    localparam logic [QUOT_W-1:0] DIR_POS_MAX = 16'h7fff;

    typedef struct packed {
        logic [ACT_W-1:0]          action;
        logic signed [FIELD_W-1:0] coord_x;
        logic signed [FIELD_W-1:0] coord_y;
        logic [DT_W-1:0]           delta_time;
    } t_in_word;

    typedef struct packed {
        logic signed [FIELD_W-1:0] pos_x;
        logic signed [FIELD_W-1:0] pos_y;
        logic signed [DIR_W-1:0]   dir_x;
        logic signed [DIR_W-1:0]   dir_y;
        logic                      arrived;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_SQUARE,
        ST_CHECK,
        ST_ROOT,
        ST_DIV_LOAD,
        ST_DIVIDE,
        ST_CLAMP,
        ST_SCALE,
        ST_UPDATE,
        ST_EMIT
    } t_state;

endpackage

### hw/rtl/mtt_divu.sv
// ----------------------------------------------------------------------------
// mtt_divu
// Restoring unsigned divider, one quotient bit per step. The numerator's
// upper part must be below the denominator so the quotient fits QUOT_W bits.
// ----------------------------------------------------------------------------
module mtt_divu
    import mtt_pkg::*;
#(
    parameter int NUM_W = 40,
    parameter int DEN_W = 25
) (
    input  logic              i_clk,
    input  logic              i_load,
    input  logic              i_step,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    output logic [QUOT_W-1:0] o_quot
);

    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [QUOT_W-1:0] r_low;
    logic [QUOT_W-1:0] r_quot;

    logic [DEN_W:0] rem2;
    logic [DEN_W:0] diff;
    logic           ge;

    always_comb begin
        rem2 = {r_rem, r_low[QUOT_W-1]};
        diff = rem2 - {1'b0, r_den};
        ge   = (rem2 >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem  <= DEN_W'(i_num[NUM_W-1:QUOT_W]);
            r_low  <= i_num[QUOT_W-1:0];
            r_den  <= i_den;
            r_quot <= '0;
        end else if (i_step) begin
            r_rem  <= ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
            r_low  <= r_low << 1;
            r_quot <= {r_quot[QUOT_W-2:0], ge};
        end
    end

    assign o_quot = r_quot;

endmodule

### hw/rtl/move_toward_target_step_core.sv
// ----------------------------------------------------------------------------
// move_toward_target_step_core
// Point mover: keeps a Q15.8 position and destination and steps the position
// toward the destination at move_speed on each tick word.
// ----------------------------------------------------------------------------
// One word is in work at a time. A tick runs bit-serial squaring, a
// COORD_WIDTH+1-bit square root at two radicand bits a cycle, the two
// bit-serial dividers for 16-bit quotients and the bit-serial speed scaling,
// plus load and update states. A tick that lands within one unit of the
// destination finishes after the squaring, and set and place words go straight
// to the output. A finished word waits in the output register while the next
// word is taken; a new result is held back only while the output register is
// still full and stalled.
// ----------------------------------------------------------------------------
module move_toward_target_step_core
    import mtt_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_word          i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_word         o_out_word,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int CW    = COORD_WIDTH;
    localparam int MW    = CW;
    localparam int RW    = MW + 1;
    localparam int SUMW  = 2 * RW;
    localparam int NUM_W = MW + QUOT_W;
    localparam int CNTW  = $clog2(RW + 1);
    localparam int PW    = ((CW > STEP_W) ? CW : STEP_W) + 2;

    localparam bit HAS_SHIFT = (CW >= 32);

    localparam logic signed [PW-1:0] CMAX = PW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] CMIN = PW'(-(64'sd1 <<< (CW - 1)));

    localparam logic [CNTW-1:0] CNT_SQUARE = CNTW'(MW - 1);
    localparam logic [CNTW-1:0] CNT_ROOT   = CNTW'(RW - 1);
    localparam logic [CNTW-1:0] CNT_QUOT   = CNTW'(QUOT_W - 1);

    function automatic logic signed [CW-1:0] sat_coord(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] c;
        if (v > CMAX) begin
            c = CMAX;
        end else if (v < CMIN) begin
            c = CMIN;
        end else begin
            c = v;
        end
        return CW'(c);
    endfunction

    // control
    t_state          r_state, n_state;
    logic [CNTW-1:0] r_cnt;
    logic            in_acc;
    logic            div_load;
    logic            div_step;
    logic            emit;
    logic            arrive;

    // configuration and architectural state
    logic [SPEED_W-1:0]  r_speed;
    logic signed [CW-1:0] r_pos_x, r_pos_y, r_tgt_x, r_tgt_y;

    // work registers
    logic                r_neg_x, r_neg_y, r_shift;
    logic [MW-1:0]       r_mag_x, r_mag_y;
    logic [MW-1:0]       r_mul_x, r_mul_y;
    logic [SUMW-1:0]     r_mcand_x, r_mcand_y;
    logic [SUMW-1:0]     r_sum;
    logic [DT_W-1:0]     r_dt;
    logic [M_W-1:0]      r_spd_sh;
    logic [M_W-1:0]      r_m;
    logic [RW:0]         r_rem;
    logic [RW-1:0]       r_root;
    logic [QUOT_W-1:0]   r_q_x, r_q_y;
    logic [PROD_W-1:0]   r_m_sh;
    logic [PROD_W-1:0]   r_acc_x, r_acc_y;

    // result registers
    logic signed [DIR_W-1:0] r_dir_x, r_dir_y;
    logic                    r_arrived;
    logic                    r_out_valid;
    t_out_word               r_out_word;

    // combinational datapath
    logic signed [CW:0]    dx, dy;
    logic [CW-1:0]         ax_raw, ay_raw, ax, ay;
    logic                  shift;
    logic signed [CW-1:0]  cx, cy;
    logic [RW+2:0]         rem2, trial;
    logic                  root_ge;
    logic [NUM_W-1:0]      num_x, num_y;
    logic [QUOT_W-1:0]     quot_x, quot_y, qx_cap, qy_cap;
    logic signed [PW-1:0]  pe_x, pe_y, st_x, st_y, nx, ny;
    logic                  cfg_wr;

    // ---------------------------------------------------------------- config
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= SPEED_RESET;
        end else if (cfg_wr && paddr[APB_AW-1:APB_IDX_LSB] == REG_MOVE_SPEED) begin
            r_speed <= pwdata[SPEED_W-1:0];
        end
    end

    assign prdata = (paddr[APB_AW-1:APB_IDX_LSB] == REG_MOVE_SPEED) ?
                    APB_DW'(r_speed) : '0;

    // ------------------------------------------------------------- sequencer
    assign arrive = !r_shift && (r_sum[SUMW-1:ARRIVE_SHIFT] == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        in_acc     = 1'b0;
        div_load   = 1'b0;
        div_step   = 1'b0;
        emit       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    in_acc  = 1'b1;
                    n_state = (i_in_word.action == ACT_TICK) ? ST_PREP : ST_EMIT;
                end
            end
            ST_PREP: begin
                n_state = ST_SQUARE;
            end
            ST_SQUARE: begin
                if (r_cnt == '0) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = arrive ? ST_EMIT : ST_ROOT;
            end
            ST_ROOT: begin
                if (r_cnt == '0) n_state = ST_DIV_LOAD;
            end
            ST_DIV_LOAD: begin
                div_load = 1'b1;
                n_state  = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                div_step = 1'b1;
                if (r_cnt == '0) n_state = ST_CLAMP;
            end
            ST_CLAMP: begin
                n_state = ST_SCALE;
            end
            ST_SCALE: begin
                if (r_cnt == '0) n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    emit    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            case (r_state)
                ST_PREP:     r_cnt <= CNT_SQUARE;
                ST_CHECK:    r_cnt <= CNT_ROOT;
                ST_DIV_LOAD: r_cnt <= CNT_QUOT;
                ST_CLAMP:    r_cnt <= CNT_QUOT;
                ST_SQUARE, ST_ROOT, ST_DIVIDE, ST_SCALE: begin
                    r_cnt <= r_cnt - 1'b1;
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------ datapath
    always_comb begin
        cx = sat_coord(PW'($signed(i_in_word.coord_x)));
        cy = sat_coord(PW'($signed(i_in_word.coord_y)));

        dx = (CW+1)'(r_tgt_x) - (CW+1)'(r_pos_x);
        dy = (CW+1)'(r_tgt_y) - (CW+1)'(r_pos_y);
        ax_raw = dx[CW] ? CW'(-dx) : CW'(dx);
        ay_raw = dy[CW] ? CW'(-dy) : CW'(dy);
        // halve both magnitudes when a difference reaches 2^(CW-1), only for CW >= 32
        shift = HAS_SHIFT && (ax_raw[CW-1] || ay_raw[CW-1]);
        ax = shift ? (ax_raw >> 1) : ax_raw;
        ay = shift ? (ay_raw >> 1) : ay_raw;

        rem2    = {r_rem, r_sum[SUMW-1 -: 2]};
        trial   = {1'b0, r_root, 2'b01};
        root_ge = (rem2 >= trial);

        num_x = (NUM_W'(r_mag_x) << DIR_FRAC) + NUM_W'(r_root >> 1);
        num_y = (NUM_W'(r_mag_y) << DIR_FRAC) + NUM_W'(r_root >> 1);

        qx_cap = (!r_neg_x && quot_x[QUOT_W-1]) ? DIR_POS_MAX : quot_x;
        qy_cap = (!r_neg_y && quot_y[QUOT_W-1]) ? DIR_POS_MAX : quot_y;

        pe_x = PW'(r_pos_x);
        pe_y = PW'(r_pos_y);
        st_x = PW'(r_acc_x[PROD_W-1:STEP_SHIFT]);
        st_y = PW'(r_acc_y[PROD_W-1:STEP_SHIFT]);
        nx   = r_neg_x ? (pe_x - st_x) : (pe_x + st_x);
        ny   = r_neg_y ? (pe_y - st_y) : (pe_y + st_y);
    end

    mtt_divu #(
        .NUM_W (NUM_W),
        .DEN_W (RW)
    ) u_div_x (
        .i_clk  (i_clk),
        .i_load (div_load),
        .i_step (div_step),
        .i_num  (num_x),
        .i_den  (r_root),
        .o_quot (quot_x)
    );

    mtt_divu #(
        .NUM_W (NUM_W),
        .DEN_W (RW)
    ) u_div_y (
        .i_clk  (i_clk),
        .i_load (div_load),
        .i_step (div_step),
        .i_num  (num_y),
        .i_den  (r_root),
        .o_quot (quot_y)
    );

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_dt     <= i_in_word.delta_time;
                    r_spd_sh <= M_W'(r_speed);
                    r_m      <= '0;
                end
            end
            ST_PREP: begin
                r_neg_x   <= dx[CW];
                r_neg_y   <= dy[CW];
                r_shift   <= shift;
                r_mag_x   <= ax;
                r_mag_y   <= ay;
                r_mul_x   <= ax;
                r_mul_y   <= ay;
                r_mcand_x <= SUMW'(ax);
                r_mcand_y <= SUMW'(ay);
                r_sum     <= '0;
            end
            ST_SQUARE: begin
                // both squares and speed*time advance one multiplier bit
                r_sum     <= r_sum + (r_mul_x[0] ? r_mcand_x : '0)
                                   + (r_mul_y[0] ? r_mcand_y : '0);
                r_mul_x   <= r_mul_x >> 1;
                r_mul_y   <= r_mul_y >> 1;
                r_mcand_x <= r_mcand_x << 1;
                r_mcand_y <= r_mcand_y << 1;
                r_m       <= r_m + (r_dt[0] ? r_spd_sh : '0);
                r_dt      <= r_dt >> 1;
                r_spd_sh  <= r_spd_sh << 1;
            end
            ST_CHECK: begin
                r_rem  <= '0;
                r_root <= '0;
            end
            ST_ROOT: begin
                // bring down two radicand bits, one root bit out
                r_rem  <= root_ge ? (RW+1)'(rem2 - trial) : rem2[RW:0];
                r_root <= {r_root[RW-2:0], root_ge};
                r_sum  <= r_sum << 2;
            end
            ST_CLAMP: begin
                r_q_x   <= qx_cap;
                r_q_y   <= qy_cap;
                r_acc_x <= PROD_W'(1) << ROUND_BIT;
                r_acc_y <= PROD_W'(1) << ROUND_BIT;
                r_m_sh  <= PROD_W'(r_m);
            end
            ST_SCALE: begin
                r_acc_x <= r_acc_x + (r_q_x[0] ? r_m_sh : '0);
                r_acc_y <= r_acc_y + (r_q_y[0] ? r_m_sh : '0);
                r_q_x   <= r_q_x >> 1;
                r_q_y   <= r_q_y >> 1;
                r_m_sh  <= r_m_sh << 1;
            end
            default: ;
        endcase
    end

    // ----------------------------------------------------- position, target
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_tgt_x <= '0;
            r_tgt_y <= '0;
        end else if (in_acc) begin
            case (i_in_word.action)
                ACT_SET_DEST: begin
                    r_tgt_x <= cx;
                    r_tgt_y <= cy;
                end
                ACT_PLACE: begin
                    r_pos_x <= cx;
                    r_pos_y <= cy;
                end
                default: ;
            endcase
        end else if (r_state == ST_CHECK && arrive) begin
            r_pos_x <= r_tgt_x;
            r_pos_y <= r_tgt_y;
        end else if (r_state == ST_UPDATE) begin
            r_pos_x <= sat_coord(nx);
            r_pos_y <= sat_coord(ny);
        end
    end

    // ---------------------------------------------------------------- result
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_dir_x   <= '0;
            r_dir_y   <= '0;
            r_arrived <= 1'b0;
        end else if (r_state == ST_CHECK && arrive) begin
            r_arrived <= 1'b1;
        end else if (r_state == ST_CLAMP) begin
            r_dir_x <= r_neg_x ? $signed(-qx_cap) : $signed(qx_cap);
            r_dir_y <= r_neg_y ? $signed(-qy_cap) : $signed(qy_cap);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_word.pos_x   <= FIELD_W'(r_pos_x);
            r_out_word.pos_y   <= FIELD_W'(r_pos_y);
            r_out_word.dir_x   <= r_dir_x;
            r_out_word.dir_y   <= r_dir_y;
            r_out_word.arrived <= r_arrived;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

### hw/rtl/mtt_chk.sv
// ----------------------------------------------------------------------------
// mtt_chk
// Port-level checks of the point mover, bound to the top level.
// ----------------------------------------------------------------------------
module mtt_chk
    import mtt_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input t_out_word         o_out_word,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [APB_AW-1:0] paddr,
    input logic [APB_DW-1:0] pwdata,
    input logic [APB_DW-1:0] prdata
);

    // reset drops any pending result word
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // one word in work at a time
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second word taken while one is in work");

    // a snap never carries a direction
    a_arrived_no_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.arrived) |->
            (o_out_word.dir_x == '0 && o_out_word.dir_y == '0))
        else $error("arrived word with nonzero direction");

    // speed register reads back what was written
    a_speed_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite &&
         paddr[APB_AW-1:APB_IDX_LSB] == REG_MOVE_SPEED)
        ##1 (paddr[APB_AW-1:APB_IDX_LSB] == REG_MOVE_SPEED) |->
            prdata == APB_DW'($past(pwdata[SPEED_W-1:0])))
        else $error("speed register readback mismatch");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled output word changed");

endmodule

bind move_toward_target_step_core mtt_chk u_mtt_chk (.*);

### tb/move_toward_target_step_core_tb.sv
// ----------------------------------------------------------------------------
// move_toward_target_step_core_tb
// Self-checking bench for the point mover. A directed table covers reset,
// coordinate extremes, the arrival boundary and direction saturation; random
// phases then run place / set / tick sequences at several speeds, including
// zero and full scale. Every output word is checked field by field against its
// table row or a fixed-point model; random idles on both sides but in one phase.
// ----------------------------------------------------------------------------
module move_toward_target_step_core_tb;
    import mtt_pkg::*;

    localparam int  RUN_LIMIT        = 1000000;
    localparam int  DRAIN_CYCLES     = 150;
    localparam int  MOVES_PER_PHASE  = 165;
    localparam int  PHASES           = 6;
    localparam int  PLAN_ROWS        = 24;

    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

    localparam logic [APB_AW-1:0] ADDR_SPEED = APB_AW'(REG_MOVE_SPEED) << APB_IDX_LSB;
    localparam logic [APB_AW-1:0] ADDR_NONE  = APB_AW'(1) << APB_IDX_LSB;

    localparam longint COORD_HI = 64'sd8388607;
    localparam longint COORD_LO = -64'sd8388608;

    localparam logic [FIELD_W-1:0] C_HI = 24'h7fffff;
    localparam logic [FIELD_W-1:0] C_LO = 24'h800000;
    localparam logic [FIELD_W-1:0] C_0  = 24'h000000;
    localparam logic [DIR_W-1:0]   D_0  = 16'h0000;
    localparam logic [DT_W-1:0]    DT_0   = 16'h0000;
    localparam logic [DT_W-1:0]    DT_MAX = 16'hffff;
    localparam t_out_word          NO_WANT = '0;

    typedef struct packed {
        t_in_word  stim;
        logic      typed;
        t_out_word want;
    } t_plan_row;

    localparam t_plan_row PLAN [PLAN_ROWS] = '{
        {ACT_TICK,     C_0,  C_0,  DT_0,   1'b1, C_0,  C_0,  D_0, D_0, 1'b1},
        {ACT_SPARE,    C_HI, C_HI, DT_MAX, 1'b1, C_0,  C_0,  D_0, D_0, 1'b0},
        {ACT_SET_DEST, C_HI, C_HI, DT_0,   1'b1, C_0,  C_0,  D_0, D_0, 1'b0},
        {ACT_PLACE,    C_LO, C_LO, DT_0,   1'b1, C_LO, C_LO, D_0, D_0, 1'b0},
        {ACT_TICK,     C_0,  C_0,  DT_MAX, 1'b0, NO_WANT},
        {ACT_TICK,     C_HI, C_LO, DT_0,   1'b0, NO_WANT},
        {ACT_SET_DEST, C_LO, C_HI, DT_MAX, 1'b0, NO_WANT},
        {ACT_TICK,     C_0,  C_0,  DT_MAX, 1'b0, NO_WANT},
        {ACT_PLACE,    C_HI, C_HI, 16'h5a5a, 1'b1, C_HI, C_HI, D_0, D_0, 1'b0},
        {ACT_SET_DEST, C_HI, C_HI, DT_0,   1'b1, C_HI, C_HI, D_0, D_0, 1'b0},
        {ACT_TICK,     C_0,  C_0,  DT_MAX, 1'b1, C_HI, C_HI, D_0, D_0, 1'b1},
        {ACT_SET_DEST, C_0,  C_0,  DT_0,   1'b1, C_HI, C_HI, D_0, D_0, 1'b0},
        // just inside one unit of the destination
        {ACT_PLACE,    24'd255, C_0, DT_0, 1'b1, 24'd255, C_0, D_0, D_0, 1'b0},
        {ACT_TICK,     C_0,  C_0,  DT_MAX, 1'b1, C_0,  C_0,  D_0, D_0, 1'b1},
        // exactly one unit away: move, negative direction at full scale
        {ACT_PLACE,    24'd256, C_0, DT_0, 1'b1, 24'd256, C_0, D_0, D_0, 1'b0},
        {ACT_TICK,     C_0,  C_0,  DT_MAX, 1'b0, NO_WANT},
        // positive direction saturates
        {ACT_PLACE,    24'hffff00, C_0, DT_0, 1'b1, 24'hffff00, C_0, D_0, D_0, 1'b0},
        {ACT_TICK,     C_0,  C_0,  DT_MAX, 1'b0, NO_WANT},
        {ACT_PLACE,    24'd181, 24'hffff4b, DT_0, 1'b1, 24'd181, 24'hffff4b, D_0, D_0, 1'b0},
        {ACT_TICK,     C_0,  C_0,  16'h1234, 1'b1, C_0, C_0, D_0, D_0, 1'b1},
        {ACT_PLACE,    24'hffff4b, 24'd182, DT_0, 1'b1, 24'hffff4b, 24'd182, D_0, D_0, 1'b0},
        {ACT_TICK,     C_0,  C_0,  DT_MAX, 1'b0, NO_WANT},
        {ACT_SPARE,    24'h123456, 24'hedcba9, 16'h8001, 1'b0, NO_WANT},
        {ACT_TICK,     C_0,  C_0,  16'h8000, 1'b0, NO_WANT}
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    t_in_word           i_in_word = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_word          o_out_word;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [APB_AW-1:0]  paddr = '0;
    logic [APB_DW-1:0]  pwdata = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    // mover model state
    longint             at_x, at_y, dest_x, dest_y;
    logic [SPEED_W-1:0] pace;

    t_out_word          queued_moves[$];
    int                 errors = 0;
    int                 cycle_count = 0;
    bit                 calm = 1'b0;

    move_toward_target_step_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic longint unsigned floor_root(input longint unsigned n);
        longint unsigned r, t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= n) r = t;
        end
        return r;
    endfunction

    // one axis of a tick: signed Q1.15 direction and the saturated new coordinate
    function automatic longint slide_axis(input longint diff, input longint unsigned mag,
                                          input longint unsigned span,
                                          input longint unsigned m, input longint pos,
                                          output logic [DIR_W-1:0] dir);
        longint unsigned q, step;
        longint moved, sdir;
        q = (mag * 64'd32768 + span / 2) / span;
        if (diff >= 0 && q > 64'd32767) q = 64'd32767;
        if (diff < 0 && q > 64'd32768) q = 64'd32768;
        step = (q * m + (64'd1 << ROUND_BIT)) >> STEP_SHIFT;
        moved = (diff < 0) ? pos - longint'(step) : pos + longint'(step);
        sdir = (diff < 0) ? -longint'(q) : longint'(q);
        dir = sdir[DIR_W-1:0];
        if (moved > COORD_HI) moved = COORD_HI;
        if (moved < COORD_LO) moved = COORD_LO;
        return moved;
    endfunction

    function automatic t_out_word advance_mover(input t_in_word w);
        t_out_word r;
        longint dx, dy;
        longint unsigned ax, ay, sum, span, m;
        logic [DIR_W-1:0] ux, uy;
        r = '0;
        if (w.action == ACT_SET_DEST) begin
            dest_x = longint'($signed(w.coord_x));
            dest_y = longint'($signed(w.coord_y));
        end else if (w.action == ACT_PLACE) begin
            at_x = longint'($signed(w.coord_x));
            at_y = longint'($signed(w.coord_y));
        end else if (w.action == ACT_TICK) begin
            dx = dest_x - at_x;
            dy = dest_y - at_y;
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            sum = ax * ax + ay * ay;
            if (sum < 64'd65536) begin
                at_x = dest_x;
                at_y = dest_y;
                r.arrived = 1'b1;
            end else begin
                span = floor_root(sum);
                m = 64'(pace) * 64'(w.delta_time);
                at_x = slide_axis(dx, ax, span, m, at_x, ux);
                at_y = slide_axis(dy, ay, span, m, at_y, uy);
                r.dir_x = ux;
                r.dir_y = uy;
            end
        end
        r.pos_x = at_x[FIELD_W-1:0];
        r.pos_y = at_y[FIELD_W-1:0];
        return r;
    endfunction

    function automatic logic [FIELD_W-1:0] roll_coord(input longint around);
        int unsigned pick;
        longint v;
        pick = $urandom_range(0, 15);
        if (pick == 0) return C_HI;
        if (pick == 1) return C_LO;
        if (pick >= 10) return FIELD_W'($urandom());
        if (pick <= 6) v = around + longint'($urandom_range(0, 1023)) - 512;
        else v = around + longint'($urandom_range(0, 131071)) - 65536;
        if (v > COORD_HI) v = COORD_HI;
        if (v < COORD_LO) v = COORD_LO;
        return v[FIELD_W-1:0];
    endfunction

    function automatic logic [DT_W-1:0] roll_dt();
        int unsigned pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) return DT_0;
        if (pick == 1) return DT_MAX;
        return DT_W'($urandom());
    endfunction

    function automatic bit roll_idle();
        return !calm && ($urandom_range(0, 99) < 17);
    endfunction

    // present one word, hold it until taken, then log what it should produce
    task automatic feed_word(input t_in_word w, input logic typed, input t_out_word want);
        t_out_word predicted;
        while (roll_idle()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = advance_mover(w);
        queued_moves.push_back(typed ? want : predicted);
    endtask

    task automatic apb_access(input bit wr, input logic [APB_AW-1:0] addr,
                              input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr[APB_AW-1:APB_IDX_LSB] == REG_MOVE_SPEED) begin
            if (wr) begin
                pace = data[SPEED_W-1:0];
            end else if (prdata[SPEED_W-1:0] !== pace) begin
                $display("%0t move_speed read expected %h actual %h",
                         $time, pace, prdata[SPEED_W-1:0]);
                errors++;
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_drained();
        while (queued_moves.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (queued_moves.size() == 0) begin
                $display("%0t unexpected word: expected none actual %h", $time, o_out_word);
                errors++;
            end else begin
                want = queued_moves.pop_front();
                if (o_out_word.pos_x !== want.pos_x) begin
                    $display("%0t pos_x expected %h actual %h", $time, want.pos_x,
                             o_out_word.pos_x);
                    errors++;
                end
                if (o_out_word.pos_y !== want.pos_y) begin
                    $display("%0t pos_y expected %h actual %h", $time, want.pos_y,
                             o_out_word.pos_y);
                    errors++;
                end
                if (o_out_word.dir_x !== want.dir_x) begin
                    $display("%0t dir_x expected %h actual %h", $time, want.dir_x,
                             o_out_word.dir_x);
                    errors++;
                end
                if (o_out_word.dir_y !== want.dir_y) begin
                    $display("%0t dir_y expected %h actual %h", $time, want.dir_y,
                             o_out_word.dir_y);
                    errors++;
                end
                if (o_out_word.arrived !== want.arrived) begin
                    $display("%0t arrived expected %b actual %b", $time, want.arrived,
                             o_out_word.arrived);
                    errors++;
                end
            end
        end
        i_out_stall <= roll_idle();
    end

    initial begin
        wait (cycle_count >= RUN_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        t_in_word w;
        int sent;
        int ticks;
        logic [APB_DW-1:0] speed_word;

        at_x = 0;
        at_y = 0;
        dest_x = 0;
        dest_y = 0;
        pace = SPEED_RESET;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        apb_access(1'b0, ADDR_SPEED, '0);
        foreach (PLAN[i]) begin
            feed_word(PLAN[i].stim, PLAN[i].typed, PLAN[i].want);
        end
        i_in_valid <= 1'b0;

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            case (ph)
                0: speed_word = 32'ha5ffffff;
                1: speed_word = 32'd0;
                2: speed_word = $urandom();
                3: speed_word = 32'd1;
                4: speed_word = {8'h00, 8'($urandom_range(0, 3)), 16'($urandom())};
                default: speed_word = 32'd256;
            endcase
            apb_access(1'b1, ADDR_SPEED, speed_word);
            if (ph == 2) apb_access(1'b1, ADDR_NONE, $urandom());
            apb_access(1'b0, ADDR_SPEED, '0);
            // no idling on either side for the whole of phase 3
            calm = (ph == 3);

            sent = 0;
            while (sent < MOVES_PER_PHASE) begin
                if ($urandom_range(0, 9) == 0) begin
                    w.action     = ACT_W'($urandom_range(0, 3));
                    w.coord_x    = FIELD_W'($urandom());
                    w.coord_y    = FIELD_W'($urandom());
                    w.delta_time = DT_W'($urandom());
                    feed_word(w, 1'b0, NO_WANT);
                    sent++;
                end else begin
                    if ($urandom_range(0, 2) != 0) begin
                        w.action     = ACT_SET_DEST;
                        w.coord_x    = roll_coord(at_x);
                        w.coord_y    = roll_coord(at_y);
                        w.delta_time = DT_W'($urandom());
                        feed_word(w, 1'b0, NO_WANT);
                        sent++;
                    end
                    if ($urandom_range(0, 1) != 0) begin
                        w.action     = ACT_PLACE;
                        w.coord_x    = roll_coord(dest_x);
                        w.coord_y    = roll_coord(dest_y);
                        w.delta_time = DT_W'($urandom());
                        feed_word(w, 1'b0, NO_WANT);
                        sent++;
                    end
                    ticks = $urandom_range(1, 8);
                    for (int t = 0; t < ticks; t++) begin
                        w.action     = ACT_TICK;
                        w.coord_x    = FIELD_W'($urandom());
                        w.coord_y    = FIELD_W'($urandom());
                        w.delta_time = roll_dt();
                        feed_word(w, 1'b0, NO_WANT);
                        sent++;
                    end
                end
            end
            i_in_valid <= 1'b0;
        end
        calm = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
